>>> rtl/pcbp_pkg.sv
// Package for the prefix code bit packer: field widths, command codes and the
// structures passed between the front end, the queue and the packing back end.
// No dependencies.
`timescale 1ns / 1ps

package pcbp_pkg;

  localparam int SYM_W     = 8;
  localparam int CODE_W    = 32;
  localparam int LEN_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int TBL_DEPTH = 256;

  // Command codes carried on in_command.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // Length an entry holds until it is first written.
  localparam logic [LEN_W-1:0] DEFAULT_LEN = 6'd8;

  // One table entry as it sits in the code RAM.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pcbp_entry_t;

  // One job handed from the front end to the back end.
  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pcbp_item_t;

endpackage

>>> rtl/pcbp_ram.sv
// Generic single-port RAM with registered read data, held when no read is made.
// No dependencies.
`timescale 1ns / 1ps

module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port share the address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pcbp_front.sv
// Front end of the packer: accepts input words, updates the code table and
// looks up encode symbols. Depends on pcbp_pkg and pcbp_ram.
`timescale 1ns / 1ps

module pcbp_front import pcbp_pkg::*; #(
  parameter int CAP_LEN = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_word,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              q_push,
  output pcbp_item_t        q_item,
  input  logic              q_full
);

  logic                 accept;
  logic                 is_write;
  logic                 is_encode;
  logic                 is_flush;
  logic [LEN_W-1:0]     len_clamped;
  pcbp_entry_t          wr_entry;
  pcbp_entry_t          rd_entry;
  logic [TBL_DEPTH-1:0] written_r;
  logic                 s1_valid_r;
  logic                 s1_flush_r;
  logic [SYM_W-1:0]     s1_sym_r;
  logic                 s1_hit_r;

  assign accept    = in_valid && in_ready;
  assign is_write  = (in_command == CMD_WRITE);
  assign is_encode = (in_command == CMD_ENCODE);
  assign is_flush  = (in_command == CMD_FLUSH);

  // Lengths above the supported maximum are saturated on the way in.
  assign len_clamped = (in_code_length > LEN_W'(CAP_LEN)) ? LEN_W'(CAP_LEN) : in_code_length;
  assign wr_entry.code = in_code_word;
  assign wr_entry.len  = len_clamped;

  pcbp_ram #(
    .WIDTH ($bits(pcbp_entry_t)),
    .DEPTH (TBL_DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (accept && is_write),
    .re    (accept && is_encode),
    .addr  (in_symbol),
    .wdata (wr_entry),
    .rdata (rd_entry)
  );

  // One flag per entry marks it as written; unwritten entries read as the
  // symbol's own 8-bit code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (accept && is_write) begin
      written_r[in_symbol] <= 1'b1;
    end
  end

  // Lookup stage: holds the word while the RAM data comes back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= accept && (is_encode || is_flush);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush_r <= is_flush;
      s1_sym_r   <= in_symbol;
      s1_hit_r   <= written_r[in_symbol];
    end
  end

  // The stage moves on whenever the queue has room.
  assign in_ready = !s1_valid_r || !q_full;
  assign q_push   = s1_valid_r && !q_full;

  assign q_item.flush = s1_flush_r;
  assign q_item.code  = s1_hit_r ? rd_entry.code : CODE_W'(s1_sym_r);
  assign q_item.len   = s1_hit_r ? rd_entry.len  : DEFAULT_LEN;

endmodule

>>> rtl/pcbp_fifo.sv
// Short queue of encode and flush jobs between the front and back ends.
// Depends on pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_fifo import pcbp_pkg::*; #(
  parameter int DEPTH = 4,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  pcbp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output pcbp_item_t head_item,
  output logic       not_empty
);

  pcbp_item_t    slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = slot_r[rd_ptr_r];

  // Pointer wrap works for any depth.
  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/pcbp_back.sv
// Back end of the packer: merges code bits into the bit accumulator and
// emits packed bytes through an output register. Depends on pcbp_pkg.
`timescale 1ns / 1ps

module pcbp_back import pcbp_pkg::*; #(
  parameter int CAP_LEN = 32,
  localparam int BUF_W = CAP_LEN + BYTE_W,
  localparam int CNT_W = $clog2(BUF_W + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pcbp_item_t        q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  logic [BUF_W-1:0]  acc_r;
  logic [BUF_W-1:0]  acc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_last_r;
  logic              slot_free;
  logic              have_byte;
  logic [CNT_W-1:0]  len_c;
  logic [CODE_W-1:0] code_mask;
  logic [CODE_W-1:0] code_m;
  logic [BUF_W-1:0]  code_ext;
  logic [CNT_W-1:0]  shamt;
  logic [BUF_W-1:0]  merged;
  logic [CNT_W-1:0]  merged_cnt;
  logic [BYTE_W-1:0] pad;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;

  assign slot_free = !out_valid_r || out_ready;
  assign have_byte = (cnt_r >= CNT_W'(BYTE_W));

  // The accumulator is left aligned: the oldest bit sits in the top bit.
  // A new code is masked to its length and placed just below the bits held.
  assign len_c      = CNT_W'(q_item.len);
  assign code_mask  = ~({CODE_W{1'b1}} << q_item.len);
  assign code_m     = q_item.code & code_mask;
  assign code_ext   = {{BYTE_W{1'b0}}, code_m[CAP_LEN-1:0]};
  assign shamt      = CNT_W'(BUF_W) - cnt_r - len_c;
  assign merged     = acc_r | (code_ext << shamt);
  assign merged_cnt = cnt_r + len_c;
  assign pad        = BYTE_W'(BYTE_W) - BYTE_W'(cnt_r);

  // A job is taken only once all full bytes of the previous one are out.
  assign q_pop = q_valid && !have_byte && slot_free;

  // Byte emission and accumulator update.
  always_comb begin
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    emit      = 1'b0;
    emit_byte = acc_r[BUF_W-1 -: BYTE_W];
    emit_last = 1'b0;
    if (have_byte && slot_free) begin
      emit      = 1'b1;
      emit_last = (cnt_r < CNT_W'(2 * BYTE_W));
      acc_nxt   = acc_r << BYTE_W;
      cnt_nxt   = cnt_r - CNT_W'(BYTE_W);
    end else if (q_pop) begin
      if (q_item.flush) begin
        emit      = (cnt_r != '0);
        emit_byte = acc_r[BUF_W-1 -: BYTE_W] | pad;
        emit_last = 1'b1;
        acc_nxt   = '0;
        cnt_nxt   = '0;
      end else if (merged_cnt >= CNT_W'(BYTE_W)) begin
        emit      = 1'b1;
        emit_byte = merged[BUF_W-1 -: BYTE_W];
        emit_last = (merged_cnt < CNT_W'(2 * BYTE_W));
        acc_nxt   = merged << BYTE_W;
        cnt_nxt   = merged_cnt - CNT_W'(BYTE_W);
      end else begin
        acc_nxt = merged;
        cnt_nxt = merged_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Output register: refilled whenever it is empty or being taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && emit) begin
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

>>> rtl/prefix_code_bit_packer_core.sv
// Top level of the prefix code bit packer: front end, job queue and back end.
// Depends on pcbp_pkg, pcbp_front, pcbp_fifo and pcbp_back.
//
//   Channel  Direction  Handshake             Word
//   in_      input      in_valid / in_ready   command, symbol, code word, code length
//   out_     output     out_valid / out_ready packed byte, last byte of run flag
//
// The input takes one word per cycle while in_ready is high. A table write finishes
// on acceptance; encode and flush words go through the lookup stage and the queue
// to the back end, which sends one byte per cycle while out_ready is high and takes
// a new word only once the last one's full bytes are sent. Reset clears the
// accumulator, the queue and the per-entry written flags; there is no clearing pass.
// A stall at the output backs up into the queue and then into in_ready.
`timescale 1ns / 1ps

module prefix_code_bit_packer_core import pcbp_pkg::*; #(
  parameter int MAX_CODE_LEN = 32,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CMD_W-1:0]  in_command,
  input  logic [SYM_W-1:0]  in_symbol,
  input  logic [CODE_W-1:0] in_code_word,
  input  logic [LEN_W-1:0]  in_code_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run
);

  // Longest code held: the parameter, bounded by the code word width.
  localparam int CAP_LEN = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic       push;
  logic       full;
  logic       pop;
  logic       not_empty;
  pcbp_item_t push_item;
  pcbp_item_t head_item;

  pcbp_front #(
    .CAP_LEN (CAP_LEN)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_symbol      (in_symbol),
    .in_code_word   (in_code_word),
    .in_code_length (in_code_length),
    .q_push         (push),
    .q_item         (push_item),
    .q_full         (full)
  );

  pcbp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .head_item (head_item),
    .not_empty (not_empty)
  );

  pcbp_back #(
    .CAP_LEN (CAP_LEN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (not_empty),
    .q_item          (head_item),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
